[rtl/dbhb_pkg.sv]
// Shared types and constants for the debounced H-bridge motor controller.
// No dependencies.
`default_nettype none

package dbhb_pkg;

    localparam int POT_W   = 10;
    localparam int TICKS_W = 10;
    localparam int DUTY_W  = 8;
    localparam int COUNT_W = 11;

    localparam logic [COUNT_W-1:0] COUNT_MAX      = 11'd1024;
    localparam logic [TICKS_W-1:0] DEBOUNCE_RESET = 10'd50;
    localparam logic [DUTY_W-1:0]  DUTY_FULL      = 8'd255;

    // per-tick control into a debouncer
    typedef struct packed {
        logic step;     // a tick is being taken
        logic examine;  // raw level is looked at on this tick
    } db_ctrl_t;

endpackage

`default_nettype wire

[rtl/dbhb_ifs.sv]
// Channel interfaces for the debounced H-bridge motor controller:
// tick request, result request and configuration write. Uses dbhb_pkg.
`default_nettype none

interface dbhb_cmd_if
    import dbhb_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              mode_button;
    logic              dir_button;
    logic [POT_W-1:0]  pot_sample;

    modport source (output valid, mode_button, dir_button, pot_sample, input ready);
    modport sink   (input valid, mode_button, dir_button, pot_sample, output ready);
endinterface

interface dbhb_status_if
    import dbhb_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              drive_a;
    logic              drive_b;
    logic [DUTY_W-1:0] pwm_duty;
    logic              motor_on;
    logic              clockwise;

    modport source (output valid, drive_a, drive_b, pwm_duty, motor_on, clockwise,
                    input ready);
    modport sink   (input valid, drive_a, drive_b, pwm_duty, motor_on, clockwise,
                    output ready);
endinterface

interface dbhb_cfg_if
    import dbhb_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [TICKS_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

[rtl/dbhb_debounce.sv]
// Button debouncer: steady-tick counter and accepted level for one button.
// Uses dbhb_pkg.
`default_nettype none

module dbhb_debounce
    import dbhb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire db_ctrl_t           ctrl,
    input  wire logic               raw,
    input  wire logic [TICKS_W-1:0] ticks,
    output logic                    rise
);

    logic               last_reg, last_next;
    logic               stable_reg, stable_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] count_up;
    logic               take;

    assign count_up = (count_reg >= COUNT_MAX) ? COUNT_MAX : count_reg + 1'b1;

    always_comb
    begin
        last_next   = last_reg;
        stable_next = stable_reg;
        count_next  = count_up;
        take        = 1'b0;
        if (ctrl.examine)
        begin
            if (raw != last_reg)
                count_next = '0;
            last_next = raw;
            take = (count_next > COUNT_W'(ticks)) && (raw != stable_reg);
            if (take)
                stable_next = raw;
        end
    end

    assign rise = take && raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg   <= 1'b0;
            stable_reg <= 1'b0;
            count_reg  <= '0;
        end
        else if (ctrl.step)
        begin
            last_reg   <= last_next;
            stable_reg <= stable_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/debounced_hbridge_motor_control_top.sv]
// Debounced two-button H-bridge motor controller, top level.
// The result request is registered and is raised in the cycle after its tick request is accepted.
// Throughput: one request per cycle; the result register doubles as the state
// and a new request is taken whenever it is empty or being drained.
// Reset: mode off, clockwise, duty 0, debounce_ticks 50, counters cleared.
// Uses dbhb_pkg, dbhb_ifs, dbhb_debounce.
`default_nettype none

module debounced_hbridge_motor_control_top
    import dbhb_pkg::*;
#(
    parameter int SAMPLE_BITS = 10
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    dbhb_cfg_if.sink     cfg,
    dbhb_cmd_if.sink     cmd,
    dbhb_status_if.source status
);

    localparam int SMAX = (1 << SAMPLE_BITS) - 1;
    localparam int XW   = POT_W + DUTY_W;
    localparam int PW   = XW + SAMPLE_BITS;
    localparam logic [POT_W-1:0] SMASK = POT_W'(SMAX);

    logic [TICKS_W-1:0] ticks_reg;
    logic               motor_reg, motor_next;
    logic               dir_reg, dir_next;
    logic [DUTY_W-1:0]  duty_reg, duty_next;
    logic               valid_reg;

    logic     accept;
    logic     mode_rise, dir_rise;
    db_ctrl_t mode_ctrl, dir_ctrl;

    logic [POT_W-1:0]  sample;
    logic [XW-1:0]     prod;
    logic [XW-1:0]     q0;
    logic [PW-1:0]     q0m;
    logic [PW-1:0]     rem;
    logic [DUTY_W-1:0] quot;

    assign cfg.ready  = 1'b1;
    assign cmd.ready  = !valid_reg || status.ready;
    assign accept     = cmd.valid && cmd.ready;

    assign mode_ctrl = '{step: accept, examine: 1'b1};
    assign dir_ctrl  = '{step: accept, examine: motor_next};

    dbhb_debounce u_mode_db (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mode_ctrl),
        .raw   (cmd.mode_button),
        .ticks (ticks_reg),
        .rise  (mode_rise)
    );

    dbhb_debounce u_dir_db (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (dir_ctrl),
        .raw   (cmd.dir_button),
        .ticks (ticks_reg),
        .rise  (dir_rise)
    );

    // duty = 255 - floor(sample * 255 / SMAX); estimate by shift, one correction
    assign sample = cmd.pot_sample & SMASK;
    assign prod   = {sample, {DUTY_W{1'b0}}} - XW'(sample);
    assign q0     = prod >> SAMPLE_BITS;
    assign q0m    = (PW'(q0) << SAMPLE_BITS) - PW'(q0);
    assign rem    = PW'(prod) - q0m;
    assign quot   = DUTY_W'(q0) + ((rem >= PW'(SMAX)) ? 8'd1 : 8'd0);

    always_comb
    begin
        motor_next = motor_reg ^ mode_rise;
        dir_next   = dir_reg;
        duty_next  = duty_reg;
        if (motor_next)
        begin
            dir_next  = dir_reg ^ dir_rise;
            duty_next = DUTY_FULL - quot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= DEBOUNCE_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            ticks_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motor_reg <= 1'b0;
            dir_reg   <= 1'b1;
            duty_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                motor_reg <= motor_next;
                dir_reg   <= dir_next;
                duty_reg  <= duty_next;
                valid_reg <= 1'b1;
            end
            else if (status.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign status.valid     = valid_reg;
    assign status.drive_a   = motor_reg && dir_reg;
    assign status.drive_b   = motor_reg && !dir_reg;
    assign status.pwm_duty  = duty_reg;
    assign status.motor_on  = motor_reg;
    assign status.clockwise = dir_reg;

    a_bridge_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(status.drive_a && status.drive_b))
        else $error("both bridge lines high");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> status.valid)
        else $error("accepted tick gave no result");

    a_duty_held: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !motor_next) |=> (duty_reg == $past(duty_reg)))
        else $error("duty changed outside motor mode");

    a_dir_held: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !motor_next) |=> (dir_reg == $past(dir_reg)))
        else $error("direction changed outside motor mode");

endmodule

`default_nettype wire
